### src/hcf_pkg.sv
// Shared types and constants for the heading complementary filter.
package hcf_pkg;
   localparam int FullTurn = 23040;
   localparam int TableLen = 24;
   localparam int ZW = 28;

   typedef enum logic [2:0] {
      REG_X_OFFSET = 3'd0, REG_Y_OFFSET = 3'd1, REG_X_HALF = 3'd2, REG_Y_HALF = 3'd3,
      REG_GYRO_BIAS = 3'd4, REG_PERIOD_GAIN = 3'd5, REG_GYRO_SHARE = 3'd6,
      REG_UNUSED = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic               command;
      logic               capture_ref;
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
      logic signed [15:0] gyro_z;
   } word_type;

   typedef struct packed {
      logic signed [15:0] x_offset;
      logic signed [15:0] y_offset;
      logic [14:0]        x_half;
      logic [14:0]        y_half;
      logic signed [15:0] gyro_bias;
      logic [15:0]        period_gain;
      logic [8:0]         gyro_share;
   } config_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0: v = 28'sd11796480;  5'd1: v = 28'sd6963869;  5'd2: v = 28'sd3679517;
         5'd3: v = 28'sd1867780;   5'd4: v = 28'sd937515;   5'd5: v = 28'sd469214;
         5'd6: v = 28'sd234664;    5'd7: v = 28'sd117339;   5'd8: v = 28'sd58671;
         5'd9: v = 28'sd29335;     5'd10: v = 28'sd14668;   5'd11: v = 28'sd7334;
         5'd12: v = 28'sd3667;     5'd13: v = 28'sd1833;    5'd14: v = 28'sd917;
         5'd15: v = 28'sd458;      5'd16: v = 28'sd229;     5'd17: v = 28'sd115;
         5'd18: v = 28'sd57;       5'd19: v = 28'sd29;      5'd20: v = 28'sd14;
         5'd21: v = 28'sd7;        5'd22: v = 28'sd4;       5'd23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

### src/hcf_front.sv
// Front end: takes input words into a two-entry queue.
module hcf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcf_pkg::word_type in_word,
   output logic              q_valid,
   input  logic              q_take,
   output hcf_pkg::word_type q_word
);
   import hcf_pkg::*;
   word_type  mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_word;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_take) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_take);
      end
   end
endmodule

### src/hcf_back.sv
// Back end: correction, iterative CORDIC, gyro increment and blend.
module hcf_back #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_take,
   input  hcf_pkg::word_type   q_word,
   input  hcf_pkg::config_type cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [14:0]         rsp_relative_heading,
   output logic [14:0]         rsp_absolute_heading
);
   import hcf_pkg::*;
   localparam int NIter = (CORDIC_ITERATIONS < TableLen) ? CORDIC_ITERATIONS : TableLen;
   localparam int VW = 36;

   typedef enum logic [2:0] {
      S_IDLE, S_PROD, S_PRE, S_ITER, S_GYRO, S_BLEND, S_OUT
   } state_type;

   state_type state_ff;
   word_type  w_ff;
   logic [4:0] it_ff;
   logic signed [VW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic                 zero_ff;
   logic signed [34:0]   r_ff;
   logic signed [15:0]   inc_ff;
   logic [14:0] heading_ff, ref_ff;
   logic [14:0] rel_ff, abs_ff;
   logic        out_ff;
   logic        out_in;

   logic signed [16:0] cx, cy;
   logic [14:0] hx, hy;
   logic signed [VW-1:0] dx, dy;
   logic signed [ZW-1:0] zr;
   logic signed [14:0] ang;
   logic [14:0] mag_a, m;
   logic signed [50:0] prod;
   logic signed [18:0] inc_full;
   logic [8:0] wt;
   logic signed [26:0] sum;
   logic signed [18:0] fused;
   logic [14:0] fused_w;
   logic signed [15:0] rel;

   assign cx = 17'(w_ff.mag_x) + 17'(cfg.x_offset);
   assign cy = 17'(w_ff.mag_y) + 17'(cfg.y_offset);
   assign hx = (cfg.x_half == '0) ? 15'd1 : cfg.x_half;
   assign hy = (cfg.y_half == '0) ? 15'd1 : cfg.y_half;
   assign dx = y_ff >>> it_ff;
   assign dy = x_ff >>> it_ff;
   assign zr = (z_ff + 28'sd2048) >>> 12;
   always_comb begin
      ang = zr[14:0];
      if (zr < 0) mag_a = 15'(zr + 28'sd23040);
      else if (zr >= 28'sd23040) mag_a = 15'(zr - 28'sd23040);
      else mag_a = ang;
      if (zero_ff) mag_a = '0;
      m = (mag_a == '0) ? 15'd0 : 15'(15'd23040 - mag_a);
   end
   assign prod = 51'(r_ff) * $signed({35'd0, cfg.period_gain});
   assign inc_full = 19'((prod + 51'sd2147483648) >>> 32);
   assign wt = (cfg.gyro_share > 9'd256) ? 9'd256 : cfg.gyro_share;
   always_comb begin
      sum = $signed({18'd0, wt}) * (27'($signed({1'b0, heading_ff})) + 27'(inc_ff))
          + $signed({18'd0, 9'd256 - wt}) * $signed({12'd0, m});
      fused = 19'((sum + 27'sd128) >>> 8);
      if (fused < 0) fused_w = 15'(fused + 19'sd23040);
      else if (fused >= 19'sd23040) fused_w = 15'(fused - 19'sd23040);
      else fused_w = fused[14:0];
      rel = $signed({1'b0, fused_w}) - $signed({1'b0, w_ff.capture_ref ? heading_ff : ref_ff});
   end

   // Hold a stalled word; load a new one when the blend finds the register free.
   always_comb begin
      out_in = out_ff && rsp_stall;
      if ((state_ff == S_BLEND) && (!out_ff || !rsp_stall)) out_in = 1'b1;
   end

   assign q_take = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = out_ff;
   assign rsp_relative_heading = rel_ff;
   assign rsp_absolute_heading = abs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_ff <= 1'b0;
         heading_ff <= '0; ref_ff <= '0;
      end else begin
         out_ff <= out_in;
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               w_ff <= q_word; state_ff <= S_PROD;
            end
            S_PROD: begin
               x_ff <= VW'(cx * $signed({1'b0, hy}));
               y_ff <= VW'(cy * $signed({1'b0, hx}));
               r_ff <= 35'(w_ff.gyro_z) * 35'sd240332 - {19'(cfg.gyro_bias), 16'd0};
               state_ff <= S_PRE;
            end
            S_PRE: begin
               zero_ff <= (x_ff == '0) && (y_ff == '0);
               it_ff <= '0;
               if (x_ff < 0) begin
                  x_ff <= -x_ff; y_ff <= -y_ff; z_ff <= 28'sd47185920;
               end else z_ff <= '0;
               state_ff <= S_ITER;
            end
            S_ITER: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + atan_entry(it_ff);
               end else begin
                  x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - atan_entry(it_ff);
               end
               it_ff <= it_ff + 5'd1;
               if (it_ff == 5'(NIter - 1)) state_ff <= S_GYRO;
            end
            S_GYRO: begin
               if (inc_full > 19'sd23039) inc_ff <= 16'sd23039;
               else if (inc_full < -19'sd23039) inc_ff <= -16'sd23039;
               else inc_ff <= inc_full[15:0];
               if (!w_ff.command) begin
                  heading_ff <= mag_a; state_ff <= S_IDLE;
               end else state_ff <= S_BLEND;
            end
            S_BLEND: if (!out_ff || !rsp_stall) begin
               if (w_ff.capture_ref) ref_ff <= heading_ff;
               heading_ff <= fused_w;
               abs_ff <= fused_w;
               rel_ff <= (rel < 0) ? 15'(rel + 16'sd23040) : rel[14:0];
               state_ff <= S_OUT;
            end
            S_OUT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### src/heading_complementary_filter.sv
// Top level of the heading complementary filter: registers, front and back ends.
//  channel | direction | handshake
//  req_    | in        | req_valid / req_stall, one word per sample or init
//  rsp_    | out       | rsp_valid / rsp_stall, one word per sample command
//  csr_    | in        | APB-style writes and reads, registers at 4*i
// In the back end a sample steps through the correction, CORDIC setup, iterative CORDIC, gyro,
// blend and output states, an init ends after the gyro state; the back end takes no new word meanwhile.
// A two-word queue takes input meanwhile.
// Reset is synchronous and restores register defaults, heading and reference to 0.
// A stalled result holds in its output register; the next blend waits for it.
module heading_complementary_filter #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic               req_capture_ref,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_relative_heading,
   output logic [14:0]        rsp_absolute_heading,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import hcf_pkg::*;
   config_type cfg_ff;
   word_type in_word, q_word;
   logic q_valid, q_take;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[4:2]);
   assign in_word = '{req_command, req_capture_ref, req_mag_x, req_mag_y, req_gyro_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'sd512, -16'sd164, 15'd840, 15'd737, 16'sd51, 16'd13107, 9'd256};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_X_OFFSET:    cfg_ff.x_offset <= csr_pwdata[15:0];
            REG_Y_OFFSET:    cfg_ff.y_offset <= csr_pwdata[15:0];
            REG_X_HALF:      cfg_ff.x_half <= csr_pwdata[14:0];
            REG_Y_HALF:      cfg_ff.y_half <= csr_pwdata[14:0];
            REG_GYRO_BIAS:   cfg_ff.gyro_bias <= csr_pwdata[15:0];
            REG_PERIOD_GAIN: cfg_ff.period_gain <= csr_pwdata[15:0];
            REG_GYRO_SHARE:  cfg_ff.gyro_share <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_X_OFFSET:    csr_prdata = 32'(cfg_ff.x_offset);
         REG_Y_OFFSET:    csr_prdata = 32'(cfg_ff.y_offset);
         REG_X_HALF:      csr_prdata = 32'(cfg_ff.x_half);
         REG_Y_HALF:      csr_prdata = 32'(cfg_ff.y_half);
         REG_GYRO_BIAS:   csr_prdata = 32'(cfg_ff.gyro_bias);
         REG_PERIOD_GAIN: csr_prdata = 32'(cfg_ff.period_gain);
         REG_GYRO_SHARE:  csr_prdata = 32'(cfg_ff.gyro_share);
         default:         csr_prdata = '0;
      endcase
   end

   hcf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .in_word,
      .q_valid, .q_take, .q_word
   );

   hcf_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_word, .cfg(cfg_ff),
      .rsp_valid, .rsp_stall, .rsp_relative_heading, .rsp_absolute_heading
   );
endmodule

### test/tb_heading_complementary_filter.sv
// Testbench for the heading complementary filter: predicts each result word and checks it.
module tb_heading_complementary_filter;
   import hcf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Iterations = 16;
   localparam int IdleLimit = 20000;
   localparam int SettleCycles = 3 * (Iterations + 5) + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = 1'b0;
   logic req_capture_ref = 1'b0;
   logic signed [15:0] req_mag_x = '0;
   logic signed [15:0] req_mag_y = '0;
   logic signed [15:0] req_gyro_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [14:0] rsp_relative_heading;
   logic [14:0] rsp_absolute_heading;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   heading_complementary_filter #(.CORDIC_ITERATIONS(Iterations)) i_dut (.*);

   typedef struct {
      logic [14:0] relative;
      logic [14:0] absolute;
   } heading_pair_type;

   heading_pair_type expected_headings[$];
   config_type cal;
   longint fused_heading, ref_heading;
   int mismatches = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   bit in_burst_gap = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint magnetic_angle(logic signed [15:0] mx, logic signed [15:0] my);
      longint cx, cy, hx, hy, x, y, z, dx, dy, a;
      cx = longint'(mx) + longint'(cal.x_offset);
      cy = longint'(my) + longint'(cal.y_offset);
      hx = (cal.x_half == 0) ? 1 : longint'(cal.x_half);
      hy = (cal.y_half == 0) ? 1 : longint'(cal.y_half);
      x = cx * hy;
      y = cy * hx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 4 * longint'(atan_entry(5'd0));
      end
      for (int i = 0; i < Iterations; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(i[4:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(i[4:0]));
         end
      end
      a = floor_shr(z + 2048, 12);
      if (a < 0) a += FullTurn;
      else if (a >= FullTurn) a -= FullTurn;
      return a;
   endfunction

   // Advance the heading state for one accepted word; queue a result for samples.
   function automatic void predict_heading(word_type w);
      longint a, m, r, inc, wt, fused, rel;
      heading_pair_type p;
      a = magnetic_angle(w.mag_x, w.mag_y);
      if (!w.command) begin
         fused_heading = a;
         return;
      end
      if (w.capture_ref) ref_heading = fused_heading;
      m = FullTurn - a;
      if (m >= FullTurn) m = 0;
      r = longint'(w.gyro_z) * 240332 - longint'(cal.gyro_bias) * 65536;
      inc = floor_shr(r * longint'(cal.period_gain) + (longint'(1) << 31), 32);
      if (inc > FullTurn - 1) inc = FullTurn - 1;
      if (inc < -(FullTurn - 1)) inc = -(FullTurn - 1);
      wt = (cal.gyro_share > 256) ? 256 : longint'(cal.gyro_share);
      fused = floor_shr(wt * (fused_heading + inc) + (256 - wt) * m + 128, 8);
      if (fused < 0) fused += FullTurn;
      else if (fused >= FullTurn) fused -= FullTurn;
      fused_heading = fused;
      rel = fused_heading - ref_heading;
      if (rel < 0) rel += FullTurn;
      p.relative = rel[14:0];
      p.absolute = fused_heading[14:0];
      expected_headings.push_back(p);
   endfunction

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_X_OFFSET: cal.x_offset = value[15:0];
         REG_Y_OFFSET: cal.y_offset = value[15:0];
         REG_X_HALF: cal.x_half = value[14:0];
         REG_Y_HALF: cal.y_half = value[14:0];
         REG_GYRO_BIAS: cal.gyro_bias = value[15:0];
         REG_PERIOD_GAIN: cal.period_gain = value[15:0];
         REG_GYRO_SHARE: cal.gyro_share = value[8:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (expected_headings.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_all(logic [31:0] xo, logic [31:0] yo, logic [31:0] xh,
                            logic [31:0] yh, logic [31:0] gb, logic [31:0] pg,
                            logic [31:0] gw);
      wait_drained();
      write_reg(REG_X_OFFSET, xo);
      write_reg(REG_Y_OFFSET, yo);
      write_reg(REG_X_HALF, xh);
      write_reg(REG_Y_HALF, yh);
      write_reg(REG_GYRO_BIAS, gb);
      write_reg(REG_PERIOD_GAIN, pg);
      write_reg(REG_GYRO_SHARE, gw);
   endtask

   // Drive one word at the falling edge and hold it until accepted.
   task automatic send_word(logic cmd, logic cap, logic [15:0] mx, logic [15:0] my,
                            logic [15:0] gz);
      word_type w;
      w.command = cmd;
      w.capture_ref = cap;
      w.mag_x = mx;
      w.mag_y = my;
      w.gyro_z = gz;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_capture_ref <= cap;
      req_mag_x <= mx;
      req_mag_y <= my;
      req_gyro_z <= gz;
      do @(posedge clock); while (req_stall);
      predict_heading(w);
      @(negedge clock);
      if (in_burst_gap || $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_word(int mode);
      logic [15:0] mx, my, gz;
      mx = $urandom;
      my = $urandom;
      gz = $urandom;
      if (mode == 1) begin
         mx = 16'($signed($urandom_range(0, 2000)) - 1000);
         my = 16'($signed($urandom_range(0, 2000)) - 1000);
         gz = 16'($signed($urandom_range(0, 4000)) - 2000);
      end
      send_word($urandom_range(0, 5) != 0, $urandom_range(0, 7) == 0, mx, my, gz);
   endtask

   task automatic test_directed();
      send_word(1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(1'b1, 1'b0, 16'h8000, 16'h8000, 16'h8000);
      send_word(1'b0, 1'b0, 16'h8000, 16'h7FFF, 16'h1234);
      send_word(1'b1, 1'b1, 16'hFE00, 16'h00A4, 16'hFFFF);
      send_word(1'b1, 1'b0, 16'h0100, 16'h0000, 16'h0001);
      send_word(1'b1, 1'b0, 16'hFF00, 16'h00A4, 16'h0000);
      send_word(1'b1, 1'b0, 16'hFE00, 16'h0200, 16'h0000);
      end_burst();
   endtask

   task automatic test_extreme_config();
      // zero half ranges, saturating gain, weight above full scale
      write_all(32'h0000_0000, 32'h0000_0000, 0, 0, 32'h0000_8000, 32'h0000_FFFF, 511);
      send_word(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b1, 1'b1, 16'h7FFF, 16'h0001, 16'h7FFF);
      send_word(1'b1, 1'b0, 16'h8000, 16'hFFFF, 16'h8000);
      send_word(1'b1, 1'b0, 16'h0000, 16'h0000, 16'h7FFF);
      end_burst();
      write_all(32'h0000_7FFF, 32'h0000_8000, 32'h7FFF, 32'h7FFF, 32'h0000_7FFF, 0, 0);
      send_word(1'b1, 1'b1, 16'h8001, 16'h7FFF, 16'h8000);
      send_word(1'b1, 1'b0, 16'h0000, 16'h8000, 16'h7FFF);
      send_word(1'b0, 1'b1, 16'h1234, 16'hABCD, 16'h0000);
      send_word(1'b1, 1'b0, 16'h4321, 16'h8765, 16'h0000);
      end_burst();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 5; phase++) begin
         write_all($urandom, $urandom, $urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom, $urandom, $urandom_range(0, 300));
         for (int n = 0; n < 40; n++) random_word(0);
         end_burst();
      end
   endtask

   task automatic test_default_like();
      write_all(512, 32'hFFFF_FF5C, 840, 737, 51, 13107, 128);
      for (int n = 0; n < 250; n++) begin
         in_burst_gap = ($urandom_range(0, 3) == 0);
         random_word(1);
         if (n == 120) begin
            // hold off until every pending result has come
            end_burst();
            while (expected_headings.size() != 0) @(negedge clock);
         end
      end
      in_burst_gap = 0;
      end_burst();
      write_all($urandom, $urandom, $urandom_range(1, 2000), $urandom_range(1, 2000),
                $urandom_range(0, 200), $urandom_range(0, 30000), $urandom_range(0, 256));
      for (int n = 0; n < 280; n++) random_word($urandom_range(0, 1));
      end_burst();
   endtask

   // Receiver stall pattern: modes switch at random, one mode never stalls.
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      heading_pair_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_headings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word rel=%0d abs=%0d",
                                           rsp_relative_heading, rsp_absolute_heading);
         end else begin
            e = expected_headings.pop_front();
            if (e.relative !== rsp_relative_heading || e.absolute !== rsp_absolute_heading)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: rel exp %0d got %0d, abs exp %0d got %0d",
                           e.relative, rsp_relative_heading, e.absolute,
                           rsp_absolute_heading);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word or register access.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      cal.x_offset = 16'sd512;
      cal.y_offset = -16'sd164;
      cal.x_half = 15'd840;
      cal.y_half = 15'd737;
      cal.gyro_bias = 16'sd51;
      cal.period_gain = 16'd13107;
      cal.gyro_share = 9'd256;
      fused_heading = 0;
      ref_heading = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_extreme_config();
      test_random_settings();
      test_default_like();
      wait_drained();
      if (mismatches == 0 && expected_headings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
